/* rtl/key_escape_sequence_encoder_top_defines.svh */
// ----------------------------------------------------------------------------
// Key escape sequence encoder assertion macros
// Shared assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_ESCAPE_SEQUENCE_ENCODER_TOP_DEFINES_SVH
`define KEY_ESCAPE_SEQUENCE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define KESE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KESE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/kese_pkg.sv */
// ----------------------------------------------------------------------------
// Key escape sequence encoder package
// Key codes, microcode word format, the microprogram and the key table.
// ----------------------------------------------------------------------------
package kese_pkg;

   localparam logic [4:0] KEY_OTHER      = 5'd0;
   localparam logic [4:0] KEY_TABLE_LAST = 5'd22;
   localparam logic [4:0] KEY_ESCAPE     = 5'd23;
   localparam logic [4:0] KEY_MOD_FIRST  = 5'd24;
   localparam logic [4:0] KEY_MOD_LAST   = 5'd28;
   localparam logic [4:0] KEY_HOME       = 5'd6;
   localparam logic [4:0] KEY_PGDOWN     = 5'd10;
   localparam logic [4:0] KEY_F4         = 5'd14;

   localparam logic [7:0] CHAR_ESC   = 8'h1B;
   localparam logic [7:0] CHAR_BRACK = 8'h5B;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   localparam int          PC_WIDTH = 5;
   localparam logic [4:0]  PROG_LEN = 5'd22;

   // Program entry points.
   localparam logic [4:0] ENTRY_ESCAPE = 5'd0;
   localparam logic [4:0] ENTRY_CURSOR = 5'd1;
   localparam logic [4:0] ENTRY_TILDE3 = 5'd8;
   localparam logic [4:0] ENTRY_TILDE4 = 5'd13;
   localparam logic [4:0] ENTRY_SHORTO = 5'd19;

   typedef enum logic [1:0] {
      OP_EMIT   = 2'd0,
      OP_JNOMOD = 2'd1,
      OP_JMOD   = 2'd2
   } ucode_op_type;

   typedef enum logic [2:0] {
      SEL_ESC   = 3'd0,
      SEL_BRACK = 3'd1,
      SEL_O     = 3'd2,
      SEL_ONE   = 3'd3,
      SEL_SEMI  = 3'd4,
      SEL_MOD   = 3'd5,
      SEL_D1    = 3'd6,
      SEL_D2    = 3'd7
   } byte_sel_type;

   typedef struct packed {
      ucode_op_type          op;
      byte_sel_type          sel;
      logic                  final_sel;  // emit the key's final byte
      logic                  last;
      logic [PC_WIDTH-1:0]   target;
   } ucode_word_type;

   typedef struct packed {
      logic [7:0] final_byte;
      logic [7:0] d1;
      logic [7:0] d2;
   } key_info_type;

   function automatic ucode_word_type emit_w(byte_sel_type sel);
      ucode_word_type w;
      w.op        = OP_EMIT;
      w.sel       = sel;
      w.final_sel = 1'b0;
      w.last      = 1'b0;
      w.target    = '0;
      return w;
   endfunction

   function automatic ucode_word_type final_w();
      ucode_word_type w;
      w           = emit_w(SEL_ESC);
      w.final_sel = 1'b1;
      w.last      = 1'b1;
      return w;
   endfunction

   function automatic ucode_word_type jump_w(ucode_op_type op, logic [PC_WIDTH-1:0] tgt);
      ucode_word_type w;
      w        = emit_w(SEL_ESC);
      w.op     = op;
      w.target = tgt;
      return w;
   endfunction

   // The microprogram. Steps 5 to 7 are the shared modifier suffix and final byte.
   function automatic ucode_word_type ucode(logic [PC_WIDTH-1:0] addr);
      ucode_word_type w;
      unique case (addr)
         5'd0: begin
            w      = emit_w(SEL_ESC);
            w.last = 1'b1;
         end
         5'd1:  w = emit_w(SEL_ESC);
         5'd2:  w = emit_w(SEL_BRACK);
         5'd3:  w = jump_w(OP_JNOMOD, 5'd7);
         5'd4:  w = emit_w(SEL_ONE);
         5'd5:  w = emit_w(SEL_SEMI);
         5'd6:  w = emit_w(SEL_MOD);
         5'd7:  w = final_w();
         5'd8:  w = emit_w(SEL_ESC);
         5'd9:  w = emit_w(SEL_BRACK);
         5'd10: w = emit_w(SEL_D1);
         5'd11: w = jump_w(OP_JMOD, 5'd5);
         5'd12: w = final_w();
         5'd13: w = emit_w(SEL_ESC);
         5'd14: w = emit_w(SEL_BRACK);
         5'd15: w = emit_w(SEL_D1);
         5'd16: w = emit_w(SEL_D2);
         5'd17: w = jump_w(OP_JMOD, 5'd5);
         5'd18: w = final_w();
         5'd19: w = emit_w(SEL_ESC);
         5'd20: w = emit_w(SEL_O);
         5'd21: w = final_w();
         default: w = final_w();
      endcase
      return w;
   endfunction

   function automatic key_info_type key_info(logic [4:0] code);
      key_info_type k;
      k.d1 = CHAR_ONE;
      k.d2 = CHAR_ONE;
      k.final_byte = CHAR_TILDE;
      unique case (code)
         5'd1:  k.final_byte = 8'h41;
         5'd2:  k.final_byte = 8'h42;
         5'd3:  k.final_byte = 8'h43;
         5'd4:  k.final_byte = 8'h44;
         5'd5:  k.final_byte = 8'h46;
         5'd6:  k.final_byte = 8'h48;
         5'd7:  k.d1 = 8'h32;
         5'd8:  k.d1 = 8'h33;
         5'd9:  k.d1 = 8'h35;
         5'd10: k.d1 = 8'h36;
         5'd11: k.final_byte = 8'h50;
         5'd12: k.final_byte = 8'h51;
         5'd13: k.final_byte = 8'h52;
         5'd14: k.final_byte = 8'h53;
         5'd15: k.d2 = 8'h35;
         5'd16: k.d2 = 8'h37;
         5'd17: k.d2 = 8'h38;
         5'd18: k.d2 = 8'h39;
         5'd19: begin
            k.d1 = 8'h32;
            k.d2 = 8'h30;
         end
         5'd20: begin
            k.d1 = 8'h32;
            k.d2 = 8'h31;
         end
         5'd21: begin
            k.d1 = 8'h32;
            k.d2 = 8'h33;
         end
         5'd22: begin
            k.d1 = 8'h32;
            k.d2 = 8'h34;
         end
         default: k.final_byte = CHAR_TILDE;
      endcase
      return k;
   endfunction

endpackage

/* rtl/key_escape_sequence_encoder_top.sv */
// ----------------------------------------------------------------------------
// Key escape sequence encoder
// Turns key press and release items into xterm style escape sequences.
// ----------------------------------------------------------------------------
// An input item is a key code and a press or release flag. Modifier items
// update the held modifier set in the cycle they are accepted and produce no
// output. A press of a cursor, editing, F1 to F12 or Escape key starts a short
// microprogram that walks a read-only control store and hands out the sequence
// byte by byte on the rsp_ channel, with rsp_last on the final byte. After the
// accept the program takes each emit step and each taken or untaken branch step
// in turn; a stalled output holds an emit step until the byte slot is free.
// The next item is taken as soon as the final byte sits in the output register.
// csr_write_data clears or sets output generation; reset leaves it enabled.
// ----------------------------------------------------------------------------
`include "key_escape_sequence_encoder_top_defines.svh"

module key_escape_sequence_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_key_code,
   input  logic       req_released,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   logic                           read_enable_ff, read_enable_in;
   logic [4:0]                     flags_ff, flags_in;
   logic                           busy_ff, busy_in;
   logic [kese_pkg::PC_WIDTH-1:0]  pc_ff, pc_in;
   logic [2:0]                     mods_ff, mods_in;
   kese_pkg::key_info_type         key_ff, key_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_byte_ff, rsp_byte_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic                           is_mod;
   logic                           start;
   logic [2:0]                     cur_mods;
   logic [kese_pkg::PC_WIDTH-1:0]  entry;
   kese_pkg::ucode_word_type       cw;
   logic                           slot_free;
   logic                           has_mod;
   logic [7:0]                     sel_byte;

   assign req_ready    = !busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   assign accept    = req_valid && req_ready;
   assign is_mod    = (req_key_code >= kese_pkg::KEY_MOD_FIRST) &&
                      (req_key_code <= kese_pkg::KEY_MOD_LAST);
   assign start     = accept && !is_mod && !req_released && read_enable_ff &&
                      (req_key_code != kese_pkg::KEY_OTHER) &&
                      (req_key_code <= kese_pkg::KEY_ESCAPE);
   assign cur_mods  = {(flags_ff[4] | flags_ff[3]), flags_ff[0], (flags_ff[2] | flags_ff[1])};
   assign cw        = kese_pkg::ucode(pc_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign has_mod   = (mods_ff != 3'd0);

   always_comb begin
      if (req_key_code == kese_pkg::KEY_ESCAPE) begin
         entry = kese_pkg::ENTRY_ESCAPE;
      end else if (req_key_code <= kese_pkg::KEY_HOME) begin
         entry = kese_pkg::ENTRY_CURSOR;
      end else if (req_key_code <= kese_pkg::KEY_PGDOWN) begin
         entry = kese_pkg::ENTRY_TILDE3;
      end else if (req_key_code <= kese_pkg::KEY_F4) begin
         // F1 to F4 take the long form only with a modifier held.
         entry = (cur_mods != 3'd0) ? kese_pkg::ENTRY_TILDE3 : kese_pkg::ENTRY_SHORTO;
      end else begin
         entry = kese_pkg::ENTRY_TILDE4;
      end
   end

   always_comb begin
      if (cw.final_sel) begin
         sel_byte = key_ff.final_byte;
      end else begin
         unique case (cw.sel)
            kese_pkg::SEL_ESC:   sel_byte = kese_pkg::CHAR_ESC;
            kese_pkg::SEL_BRACK: sel_byte = kese_pkg::CHAR_BRACK;
            kese_pkg::SEL_O:     sel_byte = kese_pkg::CHAR_O;
            kese_pkg::SEL_ONE:   sel_byte = kese_pkg::CHAR_ONE;
            kese_pkg::SEL_SEMI:  sel_byte = kese_pkg::CHAR_SEMI;
            kese_pkg::SEL_MOD:   sel_byte = kese_pkg::CHAR_ONE + {5'd0, mods_ff};
            kese_pkg::SEL_D1:    sel_byte = key_ff.d1;
            kese_pkg::SEL_D2:    sel_byte = key_ff.d2;
            default:             sel_byte = kese_pkg::CHAR_ESC;
         endcase
      end
   end

   always_comb begin
      read_enable_in = csr_write_enable ? csr_write_data : read_enable_ff;

      flags_in = flags_ff;
      if (accept && is_mod) begin
         flags_in[req_key_code[2:0]] = !req_released;
      end

      busy_in      = busy_ff;
      pc_in        = pc_ff;
      mods_in      = mods_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (start) begin
         busy_in = 1'b1;
         pc_in   = entry;
         mods_in = cur_mods;
         key_in  = kese_pkg::key_info(req_key_code);
      end else if (busy_ff) begin
         unique case (cw.op)
            kese_pkg::OP_EMIT: begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = sel_byte;
                  rsp_last_in  = cw.last;
                  if (cw.last) begin
                     busy_in = 1'b0;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
            end
            kese_pkg::OP_JNOMOD: pc_in = has_mod ? pc_ff + 1'b1 : cw.target;
            kese_pkg::OP_JMOD:   pc_in = has_mod ? cw.target : pc_ff + 1'b1;
            default:             busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_enable_ff <= 1'b1;
         flags_ff       <= '0;
         busy_ff        <= 1'b0;
         pc_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         read_enable_ff <= read_enable_in;
         flags_ff       <= flags_in;
         busy_ff        <= busy_in;
         pc_ff          <= pc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mods_ff     <= mods_in;
      key_ff      <= key_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   `KESE_ASSERT_NEXT(a_start_busy, start,
      busy_ff && (pc_ff < kese_pkg::PROG_LEN), "sequence did not start")
   `KESE_ASSERT_NOW(a_pc_range, busy_ff,
      pc_ff < kese_pkg::PROG_LEN, "program counter out of range")
   `KESE_ASSERT_NEXT(a_last_ends,
      busy_ff && (cw.op == kese_pkg::OP_EMIT) && slot_free && cw.last,
      !busy_ff && rsp_valid_ff && rsp_last_ff, "last byte did not end sequence")
   `KESE_ASSERT_NEXT(a_mod_press, accept && is_mod && !req_released,
      flags_ff != 5'd0, "modifier press lost")

endmodule
